[rtl/lzwc_pkg.sv]
// Shared types and constants for the LZW byte compressor.
// No dependencies; all files but lzwc_ram import it.
`timescale 1ns / 1ps

package lzwc_pkg;

   // Code space and dictionary geometry
   localparam int CODE_BITS   = 12;
   localparam int TABLE_SLOTS = 8192;
   localparam int IDX_W       = $clog2(TABLE_SLOTS);
   localparam int KEY_W       = CODE_BITS + 8;
   localparam int SLOT_W      = 1 + KEY_W + CODE_BITS;
   localparam int LIM_W       = 13;
   localparam int NFC_W       = CODE_BITS + 1;
   localparam int EL_W        = (NFC_W > LIM_W) ? NFC_W : LIM_W;

   localparam int FIRST_FREE  = 256;
   localparam logic [LIM_W-1:0] LIMIT_RESET = LIM_W'(4096);
   localparam logic [15:0] HASH_MULT = 16'd40503;

   // Probe unit operations
   localparam logic [1:0] OP_LOOKUP = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;

   // One dictionary slot as stored in the RAM
   typedef struct packed {
      logic                 used;
      logic [KEY_W-1:0]     key;
      logic [CODE_BITS-1:0] code;
   } slot_type;

   // Command from the stream controller to the probe unit
   typedef struct packed {
      logic                 valid;
      logic [1:0]           op;
      logic [KEY_W-1:0]     key;
      logic [CODE_BITS-1:0] code;
   } probe_cmd_type;

   // Status from the probe unit back to the stream controller
   typedef struct packed {
      logic                 ready;
      logic                 done;
      logic                 hit;
      logic [CODE_BITS-1:0] code;
      logic                 slot_ok;
   } probe_rsp_type;

   // One result item
   typedef struct packed {
      logic [CODE_BITS-1:0] code;
      logic                 final_res;
   } out_item_type;

endpackage

[rtl/lzwc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module lzwc_ram #(
   parameter int WIDTH = 33,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

[rtl/lzwc_probe.sv]
// Dictionary probe unit: hash, linear probe, insert and clearing sweep.
// Depends on lzwc_pkg and lzwc_ram.
`timescale 1ns / 1ps

module lzwc_probe
   import lzwc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  probe_cmd_type cmd,
   output probe_rsp_type rsp
);

   localparam logic [2:0] P_IDLE  = 3'd0;
   localparam logic [2:0] P_HASH  = 3'd1;
   localparam logic [2:0] P_READ  = 3'd2;
   localparam logic [2:0] P_CMP   = 3'd3;
   localparam logic [2:0] P_CLEAR = 3'd4;

   localparam logic [IDX_W-1:0] IDX_LAST = {IDX_W{1'b1}};

   logic [2:0]           state_ff, state_in;
   logic [KEY_W-1:0]     key_ff, key_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [IDX_W-1:0]     cnt_ff, cnt_in;
   logic [IDX_W-1:0]     slot_ff, slot_in;
   logic                 done_ff, done_in;
   logic                 hit_ff, hit_in;
   logic [CODE_BITS-1:0] code_ff, code_in;
   logic                 slot_ok_ff, slot_ok_in;

   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;
   slot_type             wr_slot;
   logic [IDX_W-1:0]     rd_addr;
   logic [SLOT_W-1:0]    rd_data;
   slot_type             rd_slot;
   logic [IDX_W-1:0]     hash_prod;

   assign rd_slot = slot_type'(rd_data);

   // Hash: key times a constant, low bits index the table; only the low
   // key and constant bits reach those
   assign hash_prod = key_ff[IDX_W-1:0] * IDX_W'(HASH_MULT);

   // Read the next slot early while comparing, so the next probe needs no separate read state
   assign rd_addr = (state_ff == P_CMP) ? idx_ff + 1'b1 : idx_ff;

   lzwc_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (TABLE_SLOTS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (SLOT_W'(wr_slot)),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Sequencer
   always_comb begin
      state_in   = state_ff;
      key_in     = key_ff;
      idx_in     = idx_ff;
      cnt_in     = cnt_ff;
      slot_in    = slot_ff;
      done_in    = 1'b0;
      hit_in     = hit_ff;
      code_in    = code_ff;
      slot_ok_in = slot_ok_ff;
      wr_en      = 1'b0;
      wr_addr    = slot_ff;
      wr_slot    = '0;

      case (state_ff)
         P_IDLE: begin
            if (cmd.valid) begin
               case (cmd.op)
                  OP_LOOKUP: begin
                     key_in   = cmd.key;
                     cnt_in   = '0;
                     state_in = P_HASH;
                  end
                  OP_INSERT: begin
                     wr_en        = 1'b1;
                     wr_addr      = slot_ff;
                     wr_slot.used = 1'b1;
                     wr_slot.key  = key_ff;
                     wr_slot.code = cmd.code;
                  end
                  OP_CLEAR: begin
                     idx_in   = '0;
                     state_in = P_CLEAR;
                  end
                  default: begin
                  end
               endcase
            end
         end
         P_HASH: begin
            idx_in   = hash_prod;
            state_in = P_READ;
         end
         P_READ: begin
            state_in = P_CMP;
         end
         P_CMP: begin
            if (!rd_slot.used) begin
               hit_in     = 1'b0;
               slot_ok_in = 1'b1;
               slot_in    = idx_ff;
               done_in    = 1'b1;
               state_in   = P_IDLE;
            end else if (rd_slot.key == key_ff) begin
               hit_in   = 1'b1;
               code_in  = rd_slot.code;
               done_in  = 1'b1;
               state_in = P_IDLE;
            end else if (cnt_ff == IDX_LAST) begin
               // whole table visited, no empty slot
               hit_in     = 1'b0;
               slot_ok_in = 1'b0;
               done_in    = 1'b1;
               state_in   = P_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
               cnt_in = cnt_ff + 1'b1;
            end
         end
         P_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff;
            if (idx_ff == IDX_LAST) begin
               state_in = P_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         default: begin
            state_in = P_IDLE;
         end
      endcase
   end

   // Control registers: reset starts a clearing sweep
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= P_CLEAR;
         idx_ff   <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         done_ff  <= done_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      key_ff     <= key_in;
      cnt_ff     <= cnt_in;
      slot_ff    <= slot_in;
      hit_ff     <= hit_in;
      code_ff    <= code_in;
      slot_ok_ff <= slot_ok_in;
   end

   assign rsp.ready   = (state_ff == P_IDLE);
   assign rsp.done    = done_ff;
   assign rsp.hit     = hit_ff;
   assign rsp.code    = code_ff;
   assign rsp.slot_ok = slot_ok_ff;

endmodule

[rtl/lzwc_outq.sv]
// Two-entry result queue in front of the rsp channel.
// Depends on lzwc_pkg.
`timescale 1ns / 1ps

module lzwc_outq
   import lzwc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  out_item_type push_item,
   output logic         full,
   output logic         out_valid,
   input  logic         out_stall,
   output out_item_type out_item
);

   logic [1:0]   cnt_ff, cnt_in;
   out_item_type e0_ff, e0_in;
   out_item_type e1_ff, e1_in;
   logic         pop;

   assign pop       = (cnt_ff != 2'd0) && !out_stall;
   assign full      = (cnt_ff == 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_item  = e0_ff;

   // Shift on pop, fill the first free entry on push
   always_comb begin
      cnt_in = cnt_ff;
      e0_in  = e0_ff;
      e1_in  = e1_ff;
      if (pop && push) begin
         if (cnt_ff == 2'd1) begin
            e0_in = push_item;
         end else begin
            e0_in = e1_ff;
            e1_in = push_item;
         end
      end else if (pop) begin
         e0_in  = e1_ff;
         cnt_in = cnt_ff - 2'd1;
      end else if (push) begin
         if (cnt_ff == 2'd0) begin
            e0_in = push_item;
         end else begin
            e1_in = push_item;
         end
         cnt_in = cnt_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      e0_ff <= e0_in;
      e1_ff <= e1_in;
   end

endmodule

[rtl/lzw_byte_compressor.sv]
// Top level of the LZW byte compressor: stream controller and handshakes.
// Depends on lzwc_pkg, lzwc_probe and lzwc_outq.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_stall  | req_data_byte, req_end_of_data
//   rsp     | out       | rsp_valid/rsp_stall  | rsp_code, rsp_final_res
//   csr     | in        | csr_valid/csr_ready  | csr_code_limit
//
// First byte of a stream: taken straight into the prefix. Any other byte:
// accept, hash, first read, a compare for each dictionary slot visited, take
// the probe result, then queue the code on a miss.
// End of data adds a step for the final code and a clearing sweep of all 8192
// slots (one slot per cycle). Reset starts the same sweep; csr writes are
// taken throughout. rsp_stall only holds the block once the two-entry result
// queue is full.
`timescale 1ns / 1ps

module lzw_byte_compressor
   import lzwc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [7:0]           req_data_byte,
   input  logic                 req_end_of_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [CODE_BITS-1:0] rsp_code,
   output logic                 rsp_final_res,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [LIM_W-1:0]     csr_code_limit
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_LOOK = 3'd1;
   localparam logic [2:0] S_MISS = 3'd2;
   localparam logic [2:0] S_LAST = 3'd3;

   localparam logic [EL_W-1:0] TOP_CODE   = EL_W'(1) << CODE_BITS;
   localparam logic [EL_W-1:0] FIRST_CODE = EL_W'(FIRST_FREE);

   logic [2:0]           state_ff, state_in;
   logic [CODE_BITS-1:0] prefix_ff, prefix_in;
   logic                 pv_ff, pv_in;
   logic [NFC_W-1:0]     nfc_ff, nfc_in;
   logic [LIM_W-1:0]     limit_ff;
   logic [7:0]           byte_ff, byte_in;
   logic                 last_ff, last_in;

   logic                 accept;
   logic [EL_W-1:0]      lim_ext;
   logic [EL_W-1:0]      eff_limit;
   logic                 room;
   probe_cmd_type        pcmd;
   probe_rsp_type        prsp;
   logic                 q_push;
   logic                 q_full;
   out_item_type         q_item;
   out_item_type         rsp_item;

   assign req_stall = !((state_ff == S_IDLE) && prsp.ready);
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   // Limit saturated into 256 .. 2^CODE_BITS
   assign lim_ext   = EL_W'(limit_ff);
   assign eff_limit = (lim_ext > TOP_CODE)   ? TOP_CODE :
                      (lim_ext < FIRST_CODE) ? FIRST_CODE : lim_ext;
   assign room      = (EL_W'(nfc_ff) < eff_limit);

   // Stream controller
   always_comb begin
      state_in  = state_ff;
      prefix_in = prefix_ff;
      pv_in     = pv_ff;
      nfc_in    = nfc_ff;
      byte_in   = byte_ff;
      last_in   = last_ff;
      pcmd      = '0;
      q_push    = 1'b0;
      q_item    = '0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               byte_in = req_data_byte;
               last_in = req_end_of_data;
               if (!pv_ff) begin
                  prefix_in = CODE_BITS'(req_data_byte);
                  pv_in     = 1'b1;
                  if (req_end_of_data) begin
                     state_in = S_LAST;
                  end
               end else begin
                  pcmd.valid = 1'b1;
                  pcmd.op    = OP_LOOKUP;
                  pcmd.key   = {prefix_ff, req_data_byte};
                  state_in   = S_LOOK;
               end
            end
         end
         S_LOOK: begin
            if (prsp.done) begin
               if (prsp.hit) begin
                  prefix_in = prsp.code;
                  state_in  = last_ff ? S_LAST : S_IDLE;
               end else begin
                  state_in = S_MISS;
               end
            end
         end
         S_MISS: begin
            if (!q_full) begin
               q_push           = 1'b1;
               q_item.code      = prefix_ff;
               q_item.final_res = 1'b0;
               if (room && prsp.slot_ok) begin
                  pcmd.valid = 1'b1;
                  pcmd.op    = OP_INSERT;
                  pcmd.code  = nfc_ff[CODE_BITS-1:0];
                  nfc_in     = nfc_ff + 1'b1;
               end
               prefix_in = CODE_BITS'(byte_ff);
               state_in  = last_ff ? S_LAST : S_IDLE;
            end
         end
         S_LAST: begin
            if (!q_full) begin
               q_push           = 1'b1;
               q_item.code      = prefix_ff;
               q_item.final_res = 1'b1;
               prefix_in        = '0;
               pv_in            = 1'b0;
               nfc_in           = NFC_W'(FIRST_FREE);
               pcmd.valid       = 1'b1;
               pcmd.op          = OP_CLEAR;
               state_in         = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         prefix_ff <= '0;
         pv_ff     <= 1'b0;
         nfc_ff    <= NFC_W'(FIRST_FREE);
      end else begin
         state_ff  <= state_in;
         prefix_ff <= prefix_in;
         pv_ff     <= pv_in;
         nfc_ff    <= nfc_in;
      end
   end

   // Code limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         limit_ff <= csr_code_limit;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   lzwc_probe u_probe (
      .clock (clock),
      .reset (reset),
      .cmd   (pcmd),
      .rsp   (prsp)
   );

   lzwc_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_item),
      .full      (q_full),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_item  (rsp_item)
   );

   assign rsp_code      = rsp_item.code;
   assign rsp_final_res = rsp_item.final_res;

endmodule

[rtl/lzwc_checker.sv]
// Port-level checks for the LZW byte compressor, bound to the top level.
// Depends on lzwc_pkg and lzw_byte_compressor.
`timescale 1ns / 1ps

module lzwc_checker
   import lzwc_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input logic                 req_end_of_data,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic [CODE_BITS-1:0] rsp_code,
   input logic                 rsp_final_res
);

   // A stalled result holds still
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_code) && $stable(rsp_final_res))
      else $error("rsp payload changed while stalled");

   // Dictionary sweep follows reset: no request taken right after it
   a_reset_sweep: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("request accepted during post-reset sweep");

   // End of data leads to the final code and a sweep: no request taken right after it
   a_eod_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_end_of_data |=> req_stall)
      else $error("request accepted right after end of data");

endmodule

bind lzw_byte_compressor lzwc_checker u_lzwc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .req_end_of_data (req_end_of_data),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_code        (rsp_code),
   .rsp_final_res   (rsp_final_res)
);
